// ===== design/texture_sampler_nearest_bilinear_unit_defines.svh =====
// Assertion helpers for the texture sampler.
`ifndef TEXTURE_SAMPLER_NEAREST_BILINEAR_UNIT_DEFINES_SVH
`define TEXTURE_SAMPLER_NEAREST_BILINEAR_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset only
`define TSNB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error(msg);

// next-cycle implication
`define TSNB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/tsnb_pkg.sv =====
package tsnb_pkg;

	localparam int CFG_W = 8;
	localparam int CH_W  = 8;

	// red in [2], green in [1], blue in [0]
	typedef logic [2:0][CH_W-1:0] texel_t;

	typedef enum logic [1:0] {
		CFG_TEX_WIDTH   = 2'd0,
		CFG_TEX_HEIGHT  = 2'd1,
		CFG_FILTER_MODE = 2'd2
	} cfg_idx_t;

	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	localparam logic MODE_NEAREST  = 1'b0;
	localparam logic MODE_BILINEAR = 1'b1;

endpackage

// ===== design/texture_sampler_nearest_bilinear_unit.sv =====
// A sample passes capture, scale, read, both blends and the result register to done.
// Throughput: one item per cycle; busy stays low, start is never refused.
// Texels sit in four banks split by column and row parity, so a 2x2 footprint is one read.
// Write items take the bank write port in the same stage as sample reads; they give no result.
// Reset (arst_n low) clears the valid bits and config (128 x 128, nearest); texels are kept.
`include "texture_sampler_nearest_bilinear_unit_defines.svh"

module texture_sampler_nearest_bilinear_unit import tsnb_pkg::*; #(
	parameter int MAX_WIDTH       = 128,
	parameter int MAX_HEIGHT      = 128,
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  func,
	input  logic [COORD_FRAC_BITS-1:0]            u_coord,
	input  logic [COORD_FRAC_BITS-1:0]            v_coord,
	input  logic [$clog2(MAX_WIDTH)-1:0]          write_x,
	input  logic [$clog2(MAX_HEIGHT)-1:0]         write_y,
	input  logic [CH_W-1:0]                       write_red,
	input  logic [CH_W-1:0]                       write_green,
	input  logic [CH_W-1:0]                       write_blue,
	input  logic                                  cfg_we,
	input  logic [1:0]                            cfg_idx,
	input  logic [CFG_W-1:0]                      cfg_wdata,
	output logic                                  done,
	output logic [CH_W-1:0]                       out_red,
	output logic [CH_W-1:0]                       out_green,
	output logic [CH_W-1:0]                       out_blue,
	output logic                                  in_range
);

	localparam int F       = COORD_FRAC_BITS;
	localparam int PW      = F + CFG_W;
	localparam int HW      = F + CH_W;
	localparam int VW      = 2 * F + CH_W;
	localparam int XW      = $clog2(MAX_WIDTH);
	localparam int YW      = $clog2(MAX_HEIGHT);
	localparam int HALF_W  = (MAX_WIDTH + 1) / 2;
	localparam int HALF_H  = (MAX_HEIGHT + 1) / 2;
	localparam int XHW     = (HALF_W > 1) ? $clog2(HALF_W) : 1;
	localparam int YHW     = (HALF_H > 1) ? $clog2(HALF_H) : 1;
	localparam int BANK_AW = XHW + YHW;
	localparam int BANK_DEPTH = 1 << BANK_AW;

	localparam logic [CFG_W-1:0] MAXW_C = (MAX_WIDTH > 255) ? 8'd255 : CFG_W'(MAX_WIDTH);
	localparam logic [CFG_W-1:0] MAXH_C = (MAX_HEIGHT > 255) ? 8'd255 : CFG_W'(MAX_HEIGHT);
	localparam logic [CFG_W-1:0] RST_W  = (MAX_WIDTH > 128) ? 8'd128 : CFG_W'(MAX_WIDTH);
	localparam logic [CFG_W-1:0] RST_H  = (MAX_HEIGHT > 128) ? 8'd128 : CFG_W'(MAX_HEIGHT);
	localparam logic [F:0]       ONE    = (F+1)'(1) << F;
	localparam logic [VW-1:0]    RND    = VW'(1) << (2 * F - 1);

	// configuration
	logic [CFG_W-1:0] tex_width_q, tex_height_q;
	logic             filter_mode_q;
	logic [CFG_W-1:0] w_eff, h_eff;

	// stage 1: captured item
	logic             vld_s1, func_s1;
	logic [F-1:0]     u_s1, v_s1;
	logic [XW-1:0]    wx_s1;
	logic [YW-1:0]    wy_s1;
	texel_t           wd_s1;

	// stage 2: scaled coordinates
	logic             vld_s2, func_s2;
	logic [PW-1:0]    px_s2, py_s2;
	logic [XW-1:0]    wx_s2;
	logic [YW-1:0]    wy_s2;
	texel_t           wd_s2;

	// stage 3: texel read
	logic             vld_s3, inr_s3, xp_s3, yp_s3;
	logic [F-1:0]     fx_s3, fy_s3;
	texel_t           tex_rd_s3 [4];

	// stage 4: horizontal blend
	logic             vld_s4, inr_s4;
	logic [F-1:0]     fy_s4;
	logic [HW-1:0]    h0_s4 [3];
	logic [HW-1:0]    h1_s4 [3];

	// stage 5: vertical blend
	logic             vld_s5, inr_s5;
	logic [VW-1:0]    vs_s5 [3];

	// result
	logic             done_q, in_range_q;
	texel_t           rgb_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q   <= RST_W;
			tex_height_q  <= RST_H;
			filter_mode_q <= MODE_NEAREST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_TEX_WIDTH:   tex_width_q   <= cfg_wdata;
				CFG_TEX_HEIGHT:  tex_height_q  <= cfg_wdata;
				CFG_FILTER_MODE: filter_mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// a size of zero behaves as one, oversize as the store limit
	always_comb begin
		if (tex_width_q == '0)
			w_eff = CFG_W'(1);
		else if (tex_width_q > MAXW_C)
			w_eff = MAXW_C;
		else
			w_eff = tex_width_q;
		if (tex_height_q == '0)
			h_eff = CFG_W'(1);
		else if (tex_height_q > MAXH_C)
			h_eff = MAXH_C;
		else
			h_eff = tex_height_q;
	end

	// ---------------- valid chain ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2 && (func_s2 == FUNC_SAMPLE);
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			done_q <= vld_s5;
		end
	end

	// ---------------- stage 1 ----------------
	always_ff @(posedge clk) begin
		func_s1 <= func;
		u_s1    <= u_coord;
		v_s1    <= v_coord;
		wx_s1   <= write_x;
		wy_s1   <= write_y;
		wd_s1   <= {write_red, write_green, write_blue};
	end

	// ---------------- stage 2 ----------------
	always_ff @(posedge clk) begin
		func_s2 <= func_s1;
		px_s2   <= {{CFG_W{1'b0}}, u_s1} * {{F{1'b0}}, w_eff};
		py_s2   <= {{CFG_W{1'b0}}, v_s1} * {{F{1'b0}}, h_eff};
		wx_s2   <= wx_s1;
		wy_s2   <= wy_s1;
		wd_s2   <= wd_s1;
	end

	// floor texel, fraction, footprint check and bank addresses
	logic [CFG_W-1:0]   x0, y0;
	logic [F-1:0]       fx_e, fy_e;
	logic [CFG_W:0]     x1, y1;
	logic               inr_s2;
	logic [XHW-1:0]     col_e, col_o;
	logic [YHW-1:0]     row_e, row_o;
	logic [BANK_AW-1:0] raddr [4];
	logic [BANK_AW-1:0] waddr;
	logic [1:0]         wbank;
	logic               rd_en, wr_en;

	always_comb begin
		x0   = px_s2[PW-1:F];
		y0   = py_s2[PW-1:F];
		// nearest mode is the bilinear path with both fractions at zero
		fx_e = (filter_mode_q == MODE_BILINEAR) ? px_s2[F-1:0] : '0;
		fy_e = (filter_mode_q == MODE_BILINEAR) ? py_s2[F-1:0] : '0;
		x1   = {1'b0, x0} + (CFG_W+1)'(fx_e != '0);
		y1   = {1'b0, y0} + (CFG_W+1)'(fy_e != '0);
		inr_s2 = (x1 < {1'b0, w_eff}) && (y1 < {1'b0, h_eff});

		// even bank holds whichever of x0, x0+1 is even; odd bank the odd one
		col_e = XHW'(({1'b0, x0} + {{CFG_W{1'b0}}, x0[0]}) >> 1);
		col_o = XHW'(x0 >> 1);
		row_e = YHW'(({1'b0, y0} + {{CFG_W{1'b0}}, y0[0]}) >> 1);
		row_o = YHW'(y0 >> 1);
		for (int b = 0; b < 4; b++) begin
			raddr[b] = {(b[1] ? row_o : row_e), (b[0] ? col_o : col_e)};
		end

		wbank = {wy_s2[0], wx_s2[0]};
		waddr = {YHW'(wy_s2 >> 1), XHW'(wx_s2 >> 1)};
		rd_en = vld_s2 && (func_s2 == FUNC_SAMPLE);
		wr_en = vld_s2 && (func_s2 == FUNC_WRITE)
			&& (32'(wx_s2) < MAX_WIDTH) && (32'(wy_s2) < MAX_HEIGHT);
	end

	// ---------------- texel banks (stage 3) ----------------
	for (genvar gb = 0; gb < 4; gb++) begin : g_bank
		texel_t bank_mem [BANK_DEPTH];

		always_ff @(posedge clk) begin
			if (wr_en && (wbank == 2'(gb)))
				bank_mem[waddr] <= wd_s2;
			if (rd_en)
				tex_rd_s3[gb] <= bank_mem[raddr[gb]];
		end
	end

	always_ff @(posedge clk) begin
		inr_s3 <= inr_s2;
		xp_s3  <= x0[0];
		yp_s3  <= y0[0];
		fx_s3  <= fx_e;
		fy_s3  <= fy_e;
	end

	// ---------------- stage 4: horizontal ----------------
	texel_t        t00, t10, t01, t11;
	logic          fx_z, fy_z;
	logic [F:0]    wfx0;
	logic [HW:0]   pa [3], pb [3], pc [3], pd [3];

	always_comb begin
		fx_z = (fx_s3 == '0);
		fy_z = (fy_s3 == '0);
		t00  = tex_rd_s3[{yp_s3, xp_s3}];
		// zero fraction: the ceiling texel is the floor texel itself
		t10  = fx_z ? t00 : tex_rd_s3[{yp_s3, ~xp_s3}];
		t01  = fy_z ? t00 : tex_rd_s3[{~yp_s3, xp_s3}];
		t11  = fx_z ? t01 : (fy_z ? t10 : tex_rd_s3[{~yp_s3, ~xp_s3}]);
		wfx0 = ONE - {1'b0, fx_s3};
		for (int c = 0; c < 3; c++) begin
			pa[c] = {{CH_W{1'b0}}, wfx0} * {{(F+1){1'b0}}, t00[c]};
			pb[c] = {{(CH_W+1){1'b0}}, fx_s3} * {{(F+1){1'b0}}, t10[c]};
			pc[c] = {{CH_W{1'b0}}, wfx0} * {{(F+1){1'b0}}, t01[c]};
			pd[c] = {{(CH_W+1){1'b0}}, fx_s3} * {{(F+1){1'b0}}, t11[c]};
		end
	end

	always_ff @(posedge clk) begin
		inr_s4 <= inr_s3;
		fy_s4  <= fy_s3;
		for (int c = 0; c < 3; c++) begin
			h0_s4[c] <= HW'(pa[c] + pb[c]);
			h1_s4[c] <= HW'(pc[c] + pd[c]);
		end
	end

	// ---------------- stage 5: vertical ----------------
	logic [F:0]  wfy0;
	logic [VW:0] qa [3], qb [3];

	always_comb begin
		wfy0 = ONE - {1'b0, fy_s4};
		for (int c = 0; c < 3; c++) begin
			qa[c] = {{(VW-F){1'b0}}, wfy0} * {{(VW+1-HW){1'b0}}, h0_s4[c]};
			qb[c] = {{(VW+1-F){1'b0}}, fy_s4} * {{(VW+1-HW){1'b0}}, h1_s4[c]};
		end
	end

	always_ff @(posedge clk) begin
		inr_s5 <= inr_s4;
		for (int c = 0; c < 3; c++)
			vs_s5[c] <= VW'(qa[c] + qb[c]);
	end

	// ---------------- result: round half up ----------------
	logic [VW-1:0] rsum [3];

	always_comb begin
		for (int c = 0; c < 3; c++)
			rsum[c] = vs_s5[c] + RND;
	end

	always_ff @(posedge clk) begin
		in_range_q <= inr_s5;
		for (int c = 0; c < 3; c++)
			rgb_q[c] <= inr_s5 ? rsum[c][VW-1 -: CH_W] : '0;
	end

	assign done      = done_q;
	assign in_range  = in_range_q;
	assign out_red   = rgb_q[2];
	assign out_green = rgb_q[1];
	assign out_blue  = rgb_q[0];

	// ---------------- checks ----------------
	`TSNB_ASSERT_NXT(a_done_from_pipe, vld_s5, done, "sample lost between blend and result")
	`TSNB_ASSERT_IMP(a_sample_latency, start && !busy && (func == FUNC_SAMPLE), ##6 done, "sample item gave no result on time")
	`TSNB_ASSERT_IMP(a_write_silent, start && !busy && (func == FUNC_WRITE), ##6 !done, "write item produced a result")
	`TSNB_ASSERT_IMP(a_black_outside, done && !in_range, (out_red == '0) && (out_green == '0) && (out_blue == '0), "out-of-range result not black")

endmodule

// ===== test/tb_texture_sampler_nearest_bilinear_unit.sv =====
`timescale 1ns / 100ps

module tb_texture_sampler_nearest_bilinear_unit;
	import tsnb_pkg::*;

	localparam int TEX_MAX      = 128;
	localparam int FRAC_BITS    = 16;
	localparam int STORE_WORDS  = TEX_MAX * TEX_MAX;
	localparam int ITEM_TARGET  = 1450;
	localparam int PHASE_ITEMS  = 110;
	localparam int IDLE_LIMIT   = 1000;
	localparam int DRAIN_CYCLES = 12;
	localparam int FIXED_PHASES = 10;
	// no register behind this index
	localparam logic [1:0] CFG_SPARE_IDX = 2'd3;

	typedef struct packed {
		logic        func;
		logic [15:0] u;
		logic [15:0] v;
		logic [6:0]  x;
		logic [6:0]  y;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} tex_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       in_range;
	} colour_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            start = 1'b0;
	logic            func = FUNC_WRITE;
	logic [15:0]     u_coord = '0;
	logic [15:0]     v_coord = '0;
	logic [6:0]      write_x = '0;
	logic [6:0]      write_y = '0;
	logic [CH_W-1:0] write_red = '0;
	logic [CH_W-1:0] write_green = '0;
	logic [CH_W-1:0] write_blue = '0;
	logic            cfg_we = 1'b0;
	logic [1:0]      cfg_idx = CFG_TEX_WIDTH;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic            busy;
	logic            done;
	logic [CH_W-1:0] out_red;
	logic [CH_W-1:0] out_green;
	logic [CH_W-1:0] out_blue;
	logic            in_range;

	texture_sampler_nearest_bilinear_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.u_coord     (u_coord),
		.v_coord     (v_coord),
		.write_x     (write_x),
		.write_y     (write_y),
		.write_red   (write_red),
		.write_green (write_green),
		.write_blue  (write_blue),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.done        (done),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.in_range    (in_range)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state: texel copy and register copies
	logic [23:0] texel_mem [STORE_WORDS];
	logic [7:0]  reg_width = 8'd128;
	logic [7:0]  reg_height = 8'd128;
	logic        reg_mode = MODE_NEAREST;

	// stimulus side: texels already queued for writing
	bit          texel_known [STORE_WORDS];

	tex_item_t   tex_items[$];
	colour_t     expected_colours[$];
	tex_item_t   on_port;
	bit          holding = 1'b0;
	int          burst_left = 1;
	int          gap_left = 0;
	int          idle_cycles = 0;

	int          error_count = 0;
	int          items_pushed = 0;
	int          writes_done = 0;
	int          samples_done = 0;
	int          bilinear_samples = 0;
	int          results_seen = 0;
	int          black_results = 0;
	int          phases_run = 0;

	logic [7:0]  fixed_w [FIXED_PHASES] = '{8'd1, 8'd0, 8'd255, 8'd2, 8'd128,
		8'd2, 8'd7, 8'd64, 8'd3, 8'd200};
	logic [7:0]  fixed_h [FIXED_PHASES] = '{8'd1, 8'd0, 8'd200, 8'd3, 8'd2,
		8'd128, 8'd5, 8'd64, 8'd1, 8'd129};
	logic        fixed_m [FIXED_PHASES] = '{MODE_NEAREST, MODE_BILINEAR, MODE_NEAREST,
		MODE_BILINEAR, MODE_BILINEAR, MODE_NEAREST, MODE_BILINEAR, MODE_BILINEAR,
		MODE_BILINEAR, MODE_NEAREST};

	function automatic int eff_size(input logic [7:0] r, input int maxv);
		if (r == 8'd0)
			return 1;
		if (int'(r) > maxv)
			return maxv;
		return int'(r);
	endfunction

	function automatic void split_coord(input logic [15:0] c, input int size,
			output int lo, output int hi, output longint frac);
		longint p;
		p = longint'(c) * size;
		lo = int'(p >> FRAC_BITS);
		frac = p & ((longint'(1) << FRAC_BITS) - 1);
		hi = lo + ((frac != 0) ? 1 : 0);
	endfunction

	function automatic colour_t sample_texture(input logic [15:0] u, input logic [15:0] v);
		int              w, h, x0, x1, y0, y1;
		longint          fx, fy, one, wt00, wt10, wt01, wt11, sum;
		logic [23:0]     t00, t10, t01, t11;
		logic [2:0][7:0] chan;
		colour_t         res;
		one = longint'(1) << FRAC_BITS;
		res = '0;
		w = eff_size(reg_width, TEX_MAX);
		h = eff_size(reg_height, TEX_MAX);
		split_coord(u, w, x0, x1, fx);
		split_coord(v, h, y0, y1, fy);
		if (reg_mode == MODE_NEAREST) begin
			if (x0 >= w || y0 >= h)
				return res;
			t00 = texel_mem[y0 * TEX_MAX + x0];
			chan = t00;
		end else begin
			if (x1 >= w || y1 >= h)
				return res;
			t00 = texel_mem[y0 * TEX_MAX + x0];
			t10 = texel_mem[y0 * TEX_MAX + x1];
			t01 = texel_mem[y1 * TEX_MAX + x0];
			t11 = texel_mem[y1 * TEX_MAX + x1];
			wt00 = (one - fx) * (one - fy);
			wt10 = fx * (one - fy);
			wt01 = (one - fx) * fy;
			wt11 = fx * fy;
			for (int k = 0; k < 3; k++) begin
				sum = wt00 * longint'(t00[k*8 +: 8]) + wt10 * longint'(t10[k*8 +: 8])
					+ wt01 * longint'(t01[k*8 +: 8]) + wt11 * longint'(t11[k*8 +: 8]);
				sum += longint'(1) << (2 * FRAC_BITS - 1);
				chan[k] = 8'(sum >> (2 * FRAC_BITS));
			end
		end
		res.red = chan[2];
		res.green = chan[1];
		res.blue = chan[0];
		res.in_range = 1'b1;
		return res;
	endfunction

	function automatic void apply_item(input tex_item_t it);
		if (it.func == FUNC_WRITE) begin
			texel_mem[{it.y, it.x}] = {it.red, it.green, it.blue};
			writes_done++;
		end else begin
			expected_colours.push_back(sample_texture(it.u, it.v));
			samples_done++;
			if (reg_mode == MODE_BILINEAR)
				bilinear_samples++;
		end
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			error_count++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	function automatic void push_item(input tex_item_t it);
		tex_items.push_back(it);
		items_pushed++;
	endfunction

	function automatic void queue_write(input int x, input int y,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		tex_item_t it;
		it.func = FUNC_WRITE;
		it.u = 16'($urandom);
		it.v = 16'($urandom);
		it.x = 7'(x);
		it.y = 7'(y);
		it.red = r;
		it.green = g;
		it.blue = b;
		texel_known[y * TEX_MAX + x] = 1'b1;
		push_item(it);
	endfunction

	// writes any texel of the 2x2 footprint not yet written, then the sample
	function automatic void queue_sample(input logic [15:0] u, input logic [15:0] v);
		int        xs[2], ys[2];
		longint    fx, fy;
		tex_item_t it;
		split_coord(u, eff_size(reg_width, TEX_MAX), xs[0], xs[1], fx);
		split_coord(v, eff_size(reg_height, TEX_MAX), ys[0], ys[1], fy);
		for (int i = 0; i < 2; i++)
			for (int j = 0; j < 2; j++)
				if (xs[i] < TEX_MAX && ys[j] < TEX_MAX && !texel_known[ys[j] * TEX_MAX + xs[i]])
					queue_write(xs[i], ys[j], 8'($urandom), 8'($urandom), 8'($urandom));
		it.func = FUNC_SAMPLE;
		it.u = u;
		it.v = v;
		it.x = 7'($urandom);
		it.y = 7'($urandom);
		it.red = 8'($urandom);
		it.green = 8'($urandom);
		it.blue = 8'($urandom);
		push_item(it);
	endfunction

	function automatic logic [15:0] pick_coord(input int size);
		int style, pos;
		style = $urandom_range(0, 9);
		if (style < 5)
			return 16'($urandom);
		if (style < 7) begin
			// integral scaled coordinate
			if ((size & (size - 1)) == 0)
				return 16'($urandom_range(0, size - 1) * (65536 / size));
			return 16'd0;
		end
		if (style < 9)
			return 16'(65535 - $urandom_range(0, 255));
		pos = $urandom_range(0, size - 1);
		return 16'((pos * 65536 + 32768) / size);
	endfunction

	function automatic logic [7:0] rand_size();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return 8'($urandom_range(1, 12));
		if (r == 6)
			return 8'd0;
		if (r == 7)
			return 8'd128;
		if (r == 8)
			return 8'($urandom_range(129, 255));
		return 8'($urandom_range(13, 127));
	endfunction

	task automatic drain();
		while (holding || tex_items.size() != 0 || expected_colours.size() != 0)
			@(posedge clk);
		// writes give no result, let the pipeline empty
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_TEX_WIDTH:   reg_width = val;
			CFG_TEX_HEIGHT:  reg_height = val;
			CFG_FILTER_MODE: reg_mode = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic configure(input logic [7:0] w, input logic [7:0] h, input logic mode,
			input bit spare);
		drain();
		set_reg(CFG_TEX_WIDTH, w);
		set_reg(CFG_TEX_HEIGHT, h);
		set_reg(CFG_FILTER_MODE, {7'($urandom), mode});
		if (spare || $urandom_range(0, 3) == 0)
			set_reg(CFG_SPARE_IDX, 8'($urandom));
		cfg_we <= 1'b0;
		phases_run++;
	endtask

	task automatic random_phase();
		int first;
		first = items_pushed;
		while (items_pushed - first < PHASE_ITEMS) begin
			if ($urandom_range(0, 9) < 2)
				queue_write($urandom_range(0, TEX_MAX - 1), $urandom_range(0, TEX_MAX - 1),
					8'($urandom), 8'($urandom), 8'($urandom));
			else
				queue_sample(pick_coord(eff_size(reg_width, TEX_MAX)),
					pick_coord(eff_size(reg_height, TEX_MAX)));
		end
	endtask

	// sender: bursts of items with random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			holding = 1'b0;
		end else begin
			if (start && !busy) begin
				apply_item(on_port);
				idle_cycles = 0;
			end
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
					holding = 1'b0;
				end else if (tex_items.size() != 0) begin
					on_port = tex_items.pop_front();
					func <= on_port.func;
					u_coord <= on_port.u;
					v_coord <= on_port.v;
					write_x <= on_port.x;
					write_y <= on_port.y;
					write_red <= on_port.red;
					write_green <= on_port.green;
					write_blue <= on_port.blue;
					start <= 1'b1;
					holding = 1'b1;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						if ($urandom_range(0, 7) == 0) begin
							burst_left = $urandom_range(100, 300);
							gap_left = 0;
						end else begin
							burst_left = $urandom_range(1, 20);
							gap_left = $urandom_range(0, 10);
						end
					end
				end else begin
					start <= 1'b0;
					holding = 1'b0;
				end
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		colour_t want;
		if (arst_n && done) begin
			idle_cycles = 0;
			results_seen++;
			if (!in_range)
				black_results++;
			if (expected_colours.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result: expected none, actual %0d %0d %0d in_range %0d",
					$time, out_red, out_green, out_blue, in_range);
			end else begin
				want = expected_colours.pop_front();
				check_field("out_red", want.red, out_red);
				check_field("out_green", want.green, out_green);
				check_field("out_blue", want.blue, out_blue);
				check_field("in_range", want.in_range, in_range);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (holding || tex_items.size() != 0 || expected_colours.size() != 0)
				idle_cycles++;
			else
				idle_cycles = 0;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 128 x 128, nearest; corners and extreme colours
		queue_write(0, 0, 8'd255, 8'd0, 8'd255);
		queue_write(TEX_MAX - 1, TEX_MAX - 1, 8'd0, 8'd255, 8'd0);
		queue_write(TEX_MAX - 1, 0, 8'h55, 8'haa, 8'h0f);
		queue_write(0, TEX_MAX - 1, 8'hf0, 8'h33, 8'hcc);
		queue_sample(16'h0000, 16'h0000);
		queue_sample(16'hffff, 16'hffff);
		queue_sample(16'hffff, 16'h0000);
		queue_sample(16'h0000, 16'hffff);
		queue_sample(16'h8000, 16'h8000);

		configure(8'd128, 8'd128, MODE_BILINEAR, 1'b1);
		queue_sample(16'h0000, 16'h0000);
		// ceiling past the last column and row
		queue_sample(16'hffff, 16'hffff);
		queue_sample(16'h8080, 16'h4040);
		queue_sample(16'h0100, 16'h0000);
		queue_sample(16'hfe00, 16'hfe00);

		for (int i = 0; i < FIXED_PHASES; i++) begin
			configure(fixed_w[i], fixed_h[i], fixed_m[i], 1'b0);
			random_phase();
		end
		while (items_pushed < ITEM_TARGET) begin
			configure(rand_size(), rand_size(), 1'($urandom), 1'b0);
			random_phase();
		end
		drain();

		$display("Covered %0d texel writes and %0d samples (%0d bilinear) over %0d settings",
			writes_done, samples_done, bilinear_samples, phases_run);
		$display("%0d results compared, %0d of them outside the texture", results_seen,
			black_results);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
